@@ rtl/vertex_dedup_indexer_top_defines.svh @@
// Assertion macros shared by the vertex dedup indexer RTL.
// Expect clk and rst in the scope of each use.
`ifndef VERTEX_DEDUP_INDEXER_TOP_DEFINES_SVH
`define VERTEX_DEDUP_INDEXER_TOP_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define VDI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequent in the same cycle as the antecedent.
`define VDI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after the antecedent.
`define VDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/vdi_pkg.sv @@
// Shared types and constants for the vertex dedup indexer.
// No dependencies.
package vdi_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int WORD_W           = 32;
  localparam int PAIR_W           = 2 * WORD_W;
  localparam int INDEX_W          = 10;

  typedef struct packed {
    logic load;
    logic issue;
    logic hit;
    logic append;
    logic full;
  } vdi_cmd_t;

  typedef struct packed {
    logic more;
    logic match;
    logic at_cap;
  } vdi_sts_t;

endpackage

@@ rtl/vdi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vdi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/vdi_ctrl.sv @@
// Controller for the vertex dedup indexer: load, table scan, resolve.
// Depends on vdi_pkg and vertex_dedup_indexer_top_defines.svh.
`include "vertex_dedup_indexer_top_defines.svh"
module vdi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output vdi_pkg::vdi_cmd_t cmd,
  input  vdi_pkg::vdi_sts_t sts
);
  import vdi_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FIRST = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (sts.more) begin
          cmd.issue  = 1'b1;
          state_next = ST_SCAN;
        end else begin
          cmd.append = !sts.at_cap;
          cmd.full   = sts.at_cap;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.match) begin
          cmd.hit    = 1'b1;
          state_next = ST_IDLE;
        end else if (sts.more) begin
          cmd.issue  = 1'b1;
        end else begin
          cmd.append = !sts.at_cap;
          cmd.full   = sts.at_cap;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  `VDI_ASSERT_ALWAYS(a_one_outcome, $onehot0({cmd.hit, cmd.append, cmd.full}), "two outcomes")
  `VDI_ASSERT_NEXT(a_start_enters, (state == ST_IDLE) && start, state == ST_FIRST, "start lost")
  `VDI_ASSERT_NEXT(a_issue_scans, cmd.issue, state == ST_SCAN, "read issued outside scan")
  `VDI_ASSERT_SAME(a_outcome_ends, cmd.hit || cmd.append || cmd.full, state_next == ST_IDLE,
                   "outcome without return to idle")

endmodule

@@ rtl/vdi_datapath.sv @@
// Datapath for the vertex dedup indexer: key registers, vertex table,
// scan pointer, unique count and result registers. Depends on vdi_pkg,
// vdi_ram and vertex_dedup_indexer_top_defines.svh.
`include "vertex_dedup_indexer_top_defines.svh"
module vdi_datapath #(
  parameter int MAX_VERTICES = vdi_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vdi_pkg::vdi_cmd_t             cmd,
  output vdi_pkg::vdi_sts_t             sts,
  input  logic                          first_of_mesh,
  input  logic [vdi_pkg::WORD_W-1:0]    pos_x,
  input  logic [vdi_pkg::WORD_W-1:0]    pos_y,
  input  logic [vdi_pkg::WORD_W-1:0]    pos_z,
  input  logic [vdi_pkg::WORD_W-1:0]    nrm_x,
  input  logic [vdi_pkg::WORD_W-1:0]    nrm_y,
  input  logic [vdi_pkg::WORD_W-1:0]    nrm_z,
  input  logic [vdi_pkg::WORD_W-1:0]    tex_u,
  input  logic [vdi_pkg::WORD_W-1:0]    tex_v,
  output logic                          done,
  output logic [vdi_pkg::INDEX_W-1:0]   vertex_index,
  output logic                          is_new,
  output logic                          table_full
);
  import vdi_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;
  localparam logic [CW-1:0] CAP = CW'(MAX_VERTICES);

  logic [PAIR_W-1:0] key0, key1, key2, key3;
  logic [PAIR_W-1:0] rd0, rd1, rd2, rd3;
  logic [CW-1:0]     count;
  logic [CW-1:0]     scan_idx;
  logic [AW-1:0]     cmp_idx;
  logic [AW-1:0]     wr_addr;
  logic [XW-1:0]     hit_ext;
  logic [XW-1:0]     new_ext;

  assign wr_addr = count[AW-1:0];
  assign hit_ext = XW'(cmp_idx);
  assign new_ext = XW'(wr_addr);

  vdi_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_VERTICES)) u_ram_pos_xy (
    .clk(clk), .we(cmd.append), .waddr(wr_addr), .wdata(key0),
    .raddr(scan_idx[AW-1:0]), .rdata(rd0)
  );
  vdi_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_VERTICES)) u_ram_pos_z_nrm_x (
    .clk(clk), .we(cmd.append), .waddr(wr_addr), .wdata(key1),
    .raddr(scan_idx[AW-1:0]), .rdata(rd1)
  );
  vdi_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_VERTICES)) u_ram_nrm_yz (
    .clk(clk), .we(cmd.append), .waddr(wr_addr), .wdata(key2),
    .raddr(scan_idx[AW-1:0]), .rdata(rd2)
  );
  vdi_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_VERTICES)) u_ram_tex_uv (
    .clk(clk), .we(cmd.append), .waddr(wr_addr), .wdata(key3),
    .raddr(scan_idx[AW-1:0]), .rdata(rd3)
  );

  assign sts.more   = (scan_idx < count);
  assign sts.match  = (rd0 == key0) && (rd1 == key1) && (rd2 == key2) && (rd3 == key3);
  assign sts.at_cap = (count == CAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.hit || cmd.append || cmd.full;
      if (cmd.load && first_of_mesh) begin
        count <= '0;
      end else if (cmd.append) begin
        count <= CW'(count + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key0     <= {pos_y, pos_x};
      key1     <= {nrm_x, pos_z};
      key2     <= {nrm_z, nrm_y};
      key3     <= {tex_v, tex_u};
      scan_idx <= '0;
    end else if (cmd.issue) begin
      scan_idx <= CW'(scan_idx + 1'b1);
      cmp_idx  <= scan_idx[AW-1:0];
    end
    if (cmd.hit) begin
      vertex_index <= hit_ext[INDEX_W-1:0];
      is_new       <= 1'b0;
      table_full   <= 1'b0;
    end else if (cmd.append) begin
      vertex_index <= new_ext[INDEX_W-1:0];
      is_new       <= 1'b1;
      table_full   <= 1'b0;
    end else if (cmd.full) begin
      vertex_index <= '0;
      is_new       <= 1'b0;
      table_full   <= 1'b1;
    end
  end

  `VDI_ASSERT_ALWAYS(a_count_cap, count <= CAP, "unique count above capacity")
  `VDI_ASSERT_SAME(a_append_room, cmd.append, count < CAP, "append into full table")
  `VDI_ASSERT_NEXT(a_append_grows, cmd.append, count == CW'($past(count) + 1'b1),
                   "count did not advance on append")
  `VDI_ASSERT_SAME(a_result_flags, done, !(is_new && table_full), "new and full together")

endmodule

@@ rtl/vertex_dedup_indexer_top.sv @@
// Vertex dedup indexer top level: controller plus datapath over vdi_pkg.
// A vertex matching stored entry k gives its result after the scan compares it;
// an unmatched vertex gives it after all unique_count entries are compared.
// Throughput: one transaction per result; the scan reads one table entry per
// cycle through the single read port, so time grows with unique_count.
// Reset clears the unique count and the controller; done is one cycle, no stall.
module vertex_dedup_indexer_top #(
  parameter int MAX_VERTICES = vdi_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        first_of_mesh,
  input  logic [vdi_pkg::WORD_W-1:0]  pos_x,
  input  logic [vdi_pkg::WORD_W-1:0]  pos_y,
  input  logic [vdi_pkg::WORD_W-1:0]  pos_z,
  input  logic [vdi_pkg::WORD_W-1:0]  nrm_x,
  input  logic [vdi_pkg::WORD_W-1:0]  nrm_y,
  input  logic [vdi_pkg::WORD_W-1:0]  nrm_z,
  input  logic [vdi_pkg::WORD_W-1:0]  tex_u,
  input  logic [vdi_pkg::WORD_W-1:0]  tex_v,
  output logic                        done,
  output logic [vdi_pkg::INDEX_W-1:0] vertex_index,
  output logic                        is_new,
  output logic                        table_full
);
  import vdi_pkg::*;

  vdi_cmd_t cmd;
  vdi_sts_t sts;

  vdi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  vdi_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .first_of_mesh(first_of_mesh),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z),
    .tex_u(tex_u), .tex_v(tex_v),
    .done(done), .vertex_index(vertex_index), .is_new(is_new),
    .table_full(table_full)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for vertex_dedup_indexer_top: directed table, random meshes, table fill.
// Predicts index, new and full flags per vertex transaction; depends on vdi_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vdi_pkg::*;

  localparam int          VTX_CAP     = MAX_VERTICES_DEF;
  localparam int          RAND_ITEMS  = 100;
  localparam int          DIR_N       = 23;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] pos_z;
    logic [WORD_W-1:0] nrm_x;
    logic [WORD_W-1:0] nrm_y;
    logic [WORD_W-1:0] nrm_z;
    logic [WORD_W-1:0] tex_u;
    logic [WORD_W-1:0] tex_v;
  } vertex_t;

  typedef logic [7:0][WORD_W-1:0] vertex_words_t;

  typedef enum int {
    LN_TV = 0, LN_TU, LN_NZ, LN_NY, LN_NX, LN_PZ, LN_PY, LN_PX
  } lane_e;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic               fresh;
    logic               full;
  } index_result_t;

  typedef struct {
    logic              first;
    logic [WORD_W-1:0] fill;
    lane_e             lane;
    logic [WORD_W-1:0] lane_val;
    logic              typed;
    index_result_t     want;
  } dir_row_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               start         = 1'b0;
  logic               first_of_mesh = 1'b0;
  logic [WORD_W-1:0]  pos_x         = '0;
  logic [WORD_W-1:0]  pos_y         = '0;
  logic [WORD_W-1:0]  pos_z         = '0;
  logic [WORD_W-1:0]  nrm_x         = '0;
  logic [WORD_W-1:0]  nrm_y         = '0;
  logic [WORD_W-1:0]  nrm_z         = '0;
  logic [WORD_W-1:0]  tex_u         = '0;
  logic [WORD_W-1:0]  tex_v         = '0;
  logic               busy;
  logic               done;
  logic [INDEX_W-1:0] vertex_index;
  logic               is_new;
  logic               table_full;

  vertex_t       uniq_tbl [VTX_CAP];
  int            uniq_cnt = 0;
  index_result_t index_q[$];
  int            fail_cnt = 0;
  int unsigned   cyc_cnt  = 0;
  bit            gaps_on  = 1'b1;

  dir_row_t dir_tbl [DIR_N] = '{
    '{1'b0, 32'h0000_0000, LN_PX, 32'h0000_0000, 1'b1, '{10'd0, 1'b1, 1'b0}},
    '{1'b0, 32'hFFFF_FFFF, LN_PX, 32'hFFFF_FFFF, 1'b1, '{10'd1, 1'b1, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_PX, 32'h0000_0000, 1'b1, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'hFFFF_FFFF, LN_PX, 32'hFFFF_FFFF, 1'b1, '{10'd1, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_PX, 32'h8000_0000, 1'b1, '{10'd2, 1'b1, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_NX, 32'h7FC0_0000, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_NX, 32'h7FC0_0001, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_NX, 32'h7FC0_0000, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_TV, 32'h0000_0001, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_PY, 32'h0000_0001, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_PZ, 32'h0000_0001, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_NY, 32'h0000_0001, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_NZ, 32'h0000_0001, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_TU, 32'h0000_0001, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'hFFFF_FFFF, LN_TV, 32'h7FFF_FFFF, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_PX, 32'h8000_0000, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b1, 32'hFFFF_FFFF, LN_PX, 32'hFFFF_FFFF, 1'b1, '{10'd0, 1'b1, 1'b0}},
    '{1'b0, 32'hFFFF_FFFF, LN_PX, 32'hFFFF_FFFF, 1'b1, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_PX, 32'h0000_0000, 1'b1, '{10'd1, 1'b1, 1'b0}},
    '{1'b1, 32'h0000_0000, LN_PX, 32'h0000_0000, 1'b1, '{10'd0, 1'b1, 1'b0}},
    '{1'b1, 32'h0000_0000, LN_PX, 32'h0000_0000, 1'b1, '{10'd0, 1'b1, 1'b0}},
    '{1'b0, 32'h3F80_0000, LN_PX, 32'h0000_0000, 1'b0, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 32'h0000_0000, LN_PX, 32'h0000_0000, 1'b0, '{10'd0, 1'b0, 1'b0}}
  };

  vertex_dedup_indexer_top #(
    .MAX_VERTICES(VTX_CAP)
  ) DUT (
    .*
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
  end

  function automatic index_result_t index_vertex(logic first, vertex_t v);
    index_result_t r;
    int            n;
    r = '0;
    if (first) begin
      uniq_cnt = 0;
    end
    n = uniq_cnt;
    for (int k = 0; k < n; k++) begin
      if (uniq_tbl[k] == v) begin
        r.idx = INDEX_W'(k);
        return r;
      end
    end
    if (n >= VTX_CAP) begin
      r.full = 1'b1;
      return r;
    end
    uniq_tbl[n] = v;
    uniq_cnt    = n + 1;
    r.idx       = INDEX_W'(n);
    r.fresh     = 1'b1;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    w = $urandom();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 6))
        0: w = 32'h0000_0000;
        1: w = 32'hFFFF_FFFF;
        2: w = 32'h8000_0000;
        3: w = 32'h7F80_0000;
        4: w = 32'h7FC0_0000;
        5: w = 32'hFFC0_0001;
        default: w = 32'h3F80_0000;
      endcase
    end
    return w;
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_words_t w;
    for (int i = 0; i < 8; i++) begin
      w[i] = rand_word();
    end
    return w;
  endfunction

  function automatic vertex_t flip_bit(vertex_t v);
    vertex_words_t w;
    int            lane;
    int            bit_pos;
    w       = v;
    lane    = $urandom_range(0, 7);
    bit_pos = $urandom_range(0, WORD_W - 1);
    w[lane][bit_pos] = ~w[lane][bit_pos];
    return w;
  endfunction

  function automatic void check_field(string name, logic [INDEX_W-1:0] want,
                                      logic [INDEX_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // Hold start until the controller is idle again, then predict and queue the result (or want for typed rows).
  task automatic issue_vertex(logic first, vertex_t v, logic typed, index_result_t want);
    index_result_t pred;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start         <= 1'b1;
    first_of_mesh <= first;
    pos_x         <= v.pos_x;
    pos_y         <= v.pos_y;
    pos_z         <= v.pos_z;
    nrm_x         <= v.nrm_x;
    nrm_y         <= v.nrm_y;
    nrm_z         <= v.nrm_z;
    tex_u         <= v.tex_u;
    tex_v         <= v.tex_v;
    do @(posedge clk); while (busy !== 1'b0);
    pred = index_vertex(first, v);
    index_q.insert(index_q.size(), typed ? want : pred);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (index_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    index_result_t want;
    if (!rst && done === 1'b1) begin
      if (index_q.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none actual %0h/%0b/%0b",
                 $time, vertex_index, is_new, table_full);
        fail_cnt++;
      end else begin
        want = index_q.pop_front();
        check_field("vertex_index", want.idx, vertex_index);
        check_field("is_new", INDEX_W'(want.fresh), INDEX_W'(is_new));
        check_field("table_full", INDEX_W'(want.full), INDEX_W'(table_full));
      end
    end
  end

  initial begin
    wait (cyc_cnt >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    vertex_t       v;
    vertex_words_t w;
    vertex_t       mesh_q[$];
    vertex_t       prev_q[$];
    vertex_t       fill_q[$];
    int            rand_done;
    int            mesh_len;
    int            pick;
    logic          first;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      w = {8{dir_tbl[i].fill}};
      w[dir_tbl[i].lane] = dir_tbl[i].lane_val;
      issue_vertex(dir_tbl[i].first, w, dir_tbl[i].typed, dir_tbl[i].want);
    end
    drain_results();

    rand_done = 0;
    while (rand_done < RAND_ITEMS) begin
      gaps_on  = ($urandom_range(0, 2) != 0);
      mesh_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 24);
      for (int j = 0; j < mesh_len && rand_done < RAND_ITEMS; j++) begin
        first = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
        if (first) begin
          prev_q = mesh_q;
          mesh_q.delete();
        end
        pick = $urandom_range(0, 99);
        if (mesh_q.size() != 0 && pick < 45) begin
          v = mesh_q[$urandom_range(0, mesh_q.size() - 1)];
        end else if (mesh_q.size() != 0 && pick < 55) begin
          v = flip_bit(mesh_q[$urandom_range(0, mesh_q.size() - 1)]);
        end else if (prev_q.size() != 0 && pick < 60) begin
          v = prev_q[$urandom_range(0, prev_q.size() - 1)];
        end else begin
          v = rand_vertex();
        end
        issue_vertex(first, v, 1'b0, '0);
        mesh_q.insert(mesh_q.size(), v);
        rand_done++;
      end
      if ($urandom_range(0, 19) == 0) begin
        drain_results();
      end
    end
    drain_results();

    // Fill the table to capacity, then probe around the full condition.
    gaps_on = 1'b0;
    for (int j = 0; j < VTX_CAP; j++) begin
      v = rand_vertex();
      issue_vertex(j == 0, v, 1'b0, '0);
      fill_q.insert(fill_q.size(), v);
    end
    issue_vertex(1'b0, rand_vertex(), 1'b0, '0);
    issue_vertex(1'b0, fill_q[0], 1'b0, '0);
    issue_vertex(1'b0, fill_q[VTX_CAP - 1], 1'b0, '0);
    issue_vertex(1'b0, fill_q[$urandom_range(0, VTX_CAP - 1)], 1'b0, '0);
    issue_vertex(1'b0, flip_bit(fill_q[5]), 1'b0, '0);
    issue_vertex(1'b0, rand_vertex(), 1'b0, '0);
    issue_vertex(1'b1, fill_q[7], 1'b0, '0);
    issue_vertex(1'b0, fill_q[8], 1'b0, '0);
    issue_vertex(1'b0, fill_q[7], 1'b0, '0);
    drain_results();

    repeat (VTX_CAP + 8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
